// File: rtl/expiring_input_queue_stack_unit_defines.svh
// Assertion macros shared by the RTL; empty for synthesis.
`ifndef EXPIRING_INPUT_QUEUE_STACK_UNIT_DEFINES_SVH
`define EXPIRING_INPUT_QUEUE_STACK_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define EIQS_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define EIQS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EIQS_ASSERT_ALWAYS(label, expr)
`define EIQS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/eiqs_pkg.sv
`default_nettype none
package eiqs_pkg;

    localparam int DEPTH     = 16;
    localparam int TAG_BITS  = 16;
    localparam int TIME_BITS = 32;
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 5;

    typedef enum logic {
        OP_PUSH    = 1'b0,
        OP_CONSUME = 1'b1
    } opcode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_STACK_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'b1;

    typedef struct packed {
        opcode_t              opcode;
        logic [TAG_BITS-1:0]  tag;
        logic [TIME_BITS-1:0] lifetime;
        logic [TIME_BITS-1:0] now;
    } req_item_t;

    typedef struct packed {
        logic                got_tag;
        logic [TAG_BITS-1:0] out_tag;
        logic                evicted;
        logic [CNT_W-1:0]    fill_count;
    } rsp_item_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic [TIME_BITS-1:0] push_time;
        logic [TIME_BITS-1:0] lifetime;
    } entry_t;

    // circular slot index: ptr + off, off below DEPTH
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(off);
        if (s >= (CNT_W + 1)'(DEPTH))
        begin
            s = s - (CNT_W + 1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/eiqs_if.sv
`default_nettype none
interface eiqs_req_if;
    logic                valid;
    logic                ready;
    eiqs_pkg::req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface eiqs_rsp_if;
    logic                valid;
    logic                ready;
    eiqs_pkg::rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/expiring_input_queue_stack_unit.sv
// channel  | dir | handshake    | payload
// req      | in  | valid/ready  | opcode, tag, lifetime, now
// rsp      | out | valid/ready  | got_tag, out_tag, evicted, fill_count
// cfg      | in  | cfg_we       | cfg_index, cfg_data (write only)
//
// Push: the result is registered in the cycle after accept.
// Consume: the prune reads one slot per cycle from the entry RAM and writes
// live entries back compacted; then the head (top in stack mode) is read and
// registered (empty if none live). Head pointer + count: pop/evict moves no data.
// Reset clears control state and sets config to FIFO mode, max_entries 16; the entry RAM is not cleared.
// req is taken only when idle and the result register is free or draining.
`default_nettype none
`include "expiring_input_queue_stack_unit_defines.svh"
module expiring_input_queue_stack_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    eiqs_req_if.sink                            req,
    eiqs_rsp_if.source                          rsp,
    input  wire logic                           cfg_we,
    input  wire logic [eiqs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [eiqs_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PRUNE,
        S_TAKE,
        S_OUT
    } state_t;

    state_t                           state_reg, state_next;
    logic [eiqs_pkg::PTR_W-1:0]       head_reg, head_next;
    logic [eiqs_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [eiqs_pkg::CNT_W-1:0]       rd_off_reg, rd_off_next;
    logic [eiqs_pkg::CNT_W-1:0]       wr_off_reg, wr_off_next;
    logic                             pend_reg, pend_next;
    logic [eiqs_pkg::TIME_BITS-1:0]   now_reg, now_next;
    logic                             stack_mode_reg, stack_mode_next;
    logic [eiqs_pkg::CFG_DATA_W-1:0]  max_entries_reg, max_entries_next;
    logic                             out_valid_reg, out_valid_next;
    eiqs_pkg::rsp_item_t              out_data_reg, out_data_next;

    eiqs_pkg::entry_t                 mem [eiqs_pkg::DEPTH];
    logic                             mem_we;
    logic [eiqs_pkg::PTR_W-1:0]       mem_waddr;
    eiqs_pkg::entry_t                 mem_wdata;
    logic                             mem_re;
    logic [eiqs_pkg::PTR_W-1:0]       mem_raddr;
    eiqs_pkg::entry_t                 mem_q;

    logic                             req_fire;
    logic [eiqs_pkg::CNT_W-1:0]       cap;
    logic [eiqs_pkg::TIME_BITS-1:0]   age;
    logic                             live;
    logic [eiqs_pkg::CNT_W-1:0]       kept;
    logic [eiqs_pkg::PTR_W-1:0]       push_head;

    function automatic logic [eiqs_pkg::PTR_W-1:0] wrap_add_one(
        input logic [eiqs_pkg::PTR_W-1:0] p);
        return eiqs_pkg::wrap_add(p, eiqs_pkg::CNT_W'(1));
    endfunction

    always_comb
    begin
        if (max_entries_reg == '0)
        begin
            cap = eiqs_pkg::CNT_W'(1);
        end
        else if (eiqs_pkg::CNT_W'(max_entries_reg) > eiqs_pkg::CNT_W'(eiqs_pkg::DEPTH)
                 || max_entries_reg > eiqs_pkg::CFG_DATA_W'(eiqs_pkg::DEPTH))
        begin
            cap = eiqs_pkg::CNT_W'(eiqs_pkg::DEPTH);
        end
        else
        begin
            cap = eiqs_pkg::CNT_W'(max_entries_reg);
        end
    end

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign age  = now_reg - mem_q.push_time;
    assign live = (age <= mem_q.lifetime);

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        rd_off_next      = rd_off_reg;
        wr_off_next      = wr_off_reg;
        pend_next        = 1'b0;
        now_next         = now_reg;
        stack_mode_next  = stack_mode_reg;
        max_entries_next = max_entries_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_data_next    = out_data_reg;
        mem_we           = 1'b0;
        mem_waddr        = head_reg;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = head_reg;
        kept             = count_reg;
        push_head        = head_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                eiqs_pkg::CFG_STACK_MODE:  stack_mode_next  = cfg_data[0];
                eiqs_pkg::CFG_MAX_ENTRIES: max_entries_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next.fill_count = count_reg;
                    if (req.data.opcode == eiqs_pkg::OP_PUSH)
                    begin
                        if (req.data.tag != '0)
                        begin
                            // full: drop oldest, count stays; else grow by one
                            if (count_reg >= cap && count_reg != '0)
                            begin
                                push_head = wrap_add_one(head_reg);
                                kept      = count_reg - 1'b1;
                                out_data_next.evicted = 1'b1;
                            end
                            head_next   = push_head;
                            count_next  = kept + 1'b1;
                            mem_we      = 1'b1;
                            mem_waddr   = eiqs_pkg::wrap_add(push_head, kept);
                            mem_wdata.tag       = req.data.tag;
                            mem_wdata.push_time = req.data.now;
                            mem_wdata.lifetime  = req.data.lifetime;
                            out_data_next.fill_count = kept + 1'b1;
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                        now_next       = req.data.now;
                        rd_off_next    = '0;
                        wr_off_next    = '0;
                        state_next     = S_PRUNE;
                    end
                end
            end
            S_PRUNE:
            begin
                if (rd_off_reg < count_reg)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = eiqs_pkg::wrap_add(head_reg, rd_off_reg);
                    rd_off_next = rd_off_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                // writes land at or behind slots already read
                if (pend_reg && live)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = eiqs_pkg::wrap_add(head_reg, wr_off_reg);
                    mem_wdata   = mem_q;
                    wr_off_next = wr_off_reg + 1'b1;
                end
                if (rd_off_reg == count_reg && !pend_reg)
                begin
                    count_next = wr_off_reg;
                    state_next = S_TAKE;
                end
            end
            S_TAKE:
            begin
                if (count_reg == '0)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = stack_mode_reg
                               ? eiqs_pkg::wrap_add(head_reg, count_reg - 1'b1)
                               : head_reg;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = '0;
                out_data_next.got_tag    = 1'b1;
                out_data_next.out_tag    = mem_q.tag;
                out_data_next.fill_count = count_reg - 1'b1;
                count_next = count_reg - 1'b1;
                if (!stack_mode_reg)
                begin
                    head_next = wrap_add_one(head_reg);
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            count_reg       <= '0;
            rd_off_reg      <= '0;
            wr_off_reg      <= '0;
            pend_reg        <= 1'b0;
            now_reg         <= '0;
            stack_mode_reg  <= 1'b0;
            max_entries_reg <= eiqs_pkg::CFG_DATA_W'(16);
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            rd_off_reg      <= rd_off_next;
            wr_off_reg      <= wr_off_next;
            pend_reg        <= pend_next;
            now_reg         <= now_next;
            stack_mode_reg  <= stack_mode_next;
            max_entries_reg <= max_entries_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    `EIQS_ASSERT_ALWAYS(a_count_bound, count_reg <= eiqs_pkg::CNT_W'(eiqs_pkg::DEPTH))
    `EIQS_ASSERT_ALWAYS(a_compact_order, wr_off_reg <= rd_off_reg)
    `EIQS_ASSERT_NEXT(a_push_result, req_fire && req.data.opcode == eiqs_pkg::OP_PUSH, out_valid_reg)
    `EIQS_ASSERT_ALWAYS(a_evict_full, !(out_valid_reg && out_data_reg.evicted) || out_data_reg.fill_count != '0)

endmodule
`default_nettype wire
